/* rtl/afw_pkg.sv */
// afw_pkg: types, constants and register codes for the aspect fit window calculator
// used by aspect_fit_window_calc; no dependencies
`default_nettype none

package afw_pkg;

    // field widths
    localparam int DIM_W = 12;
    localparam int OFS_W = 11;
    localparam int PROD_W = 2 * DIM_W;

    // divider: quotient bits resolved per pipeline stage
    localparam int DIV_BITS = 2;
    localparam int DIV_STAGES = DIM_W / DIV_BITS;
    // prep, product, divider setup, divider stages, output
    localparam int NSTG = DIV_STAGES + 4;

    // stream payload widths, padded to whole bytes
    localparam int IN_TDATA_W = 40;
    localparam int OUT_TDATA_W = 72;

    // configuration port
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam logic [DIM_W-1:0] PANEL_W_RST = 12'd1920;
    localparam logic [DIM_W-1:0] PANEL_H_RST = 12'd1080;

    typedef enum logic [0:0] {
        REG_PANEL_W = 1'b0,
        REG_PANEL_H = 1'b1
    } t_reg_idx;

    // fit modes, anything else is auto
    localparam logic [2:0] MODE_ORIG = 3'd2;
    localparam logic [2:0] MODE_4_3 = 3'd3;
    localparam logic [2:0] MODE_16_9 = 3'd4;
    localparam logic [2:0] MODE_221 = 3'd5;

    // sequence header aspect codes
    localparam logic [3:0] ASP_4_3 = 4'd2;
    localparam logic [3:0] ASP_16_9 = 4'd3;
    localparam logic [3:0] ASP_221 = 4'd4;

    // ratios scaled by 900
    localparam logic [DIM_W-1:0] RATIO_UNIT = 12'd900;
    localparam logic [DIM_W-1:0] RATIO_4_3 = 12'd1200;
    localparam logic [DIM_W-1:0] RATIO_16_9 = 12'd1600;
    localparam logic [DIM_W-1:0] RATIO_221 = 12'd1989;

    // source size special cases
    localparam logic [DIM_W-1:0] MIN_W = 12'd16;
    localparam logic [DIM_W-1:0] MIN_H = 12'd9;
    localparam logic [DIM_W-1:0] HD_W = 12'd1920;
    localparam logic [DIM_W-1:0] HD_H_CODED = 12'd1088;
    localparam logic [DIM_W-1:0] HD_H = 12'd1080;
    localparam logic [DIM_W-1:0] PAL_W = 12'd720;
    localparam logic [DIM_W-1:0] PAL_H = 12'd576;
    localparam logic [DIM_W-1:0] PAL_4_3_W = 12'd768;

    typedef struct packed {
        logic [DIM_W-1:0] iw;
        logic [DIM_W-1:0] ih;
        logic             orig;
        logic [DIM_W-1:0] w;
        logic [DIM_W-1:0] h;
    } t_prep;

    typedef struct packed {
        logic [DIM_W-1:0]  iw;
        logic [DIM_W-1:0]  ih;
        logic              orig;
        logic [DIM_W-1:0]  w;
        logic [DIM_W-1:0]  h;
        logic [PROD_W-1:0] wph;   // w * panel_height
        logic [PROD_W-1:0] pwh;   // panel_width * h
    } t_prod;

    typedef struct packed {
        logic [DIM_W-1:0] iw;
        logic [DIM_W-1:0] ih;
        logic             orig;
        logic             wide;   // width fills the panel
        logic [DIM_W-1:0] rem;
        logic [DIM_W-1:0] num;    // dividend bits not yet shifted in
        logic [DIM_W-1:0] den;
        logic [DIM_W-1:0] q;
    } t_div;

    typedef struct packed {
        logic [DIM_W-1:0] out_h;
        logic [DIM_W-1:0] out_w;
        logic [OFS_W-1:0] out_y;
        logic [OFS_W-1:0] out_x;
        logic [DIM_W-1:0] src_h;
        logic [DIM_W-1:0] src_w;
    } t_res;

endpackage

`default_nettype wire

/* rtl/aspect_fit_window_calc.sv */
// aspect_fit_window_calc: letterbox / pillarbox window fit, top level
// the input beat passes the prep, product, divider setup, divider and output
// stage registers to the result beat; throughput: one beat per cycle, each
// stage fed every cycle, while the output is not stalled; the restoring
// divider resolves two quotient bits per stage over six stages; i_rst_n is
// synchronous, active low: clears all stage valid bits and loads the panel
// registers with 1920x1080; payload registers are not reset; depends on afw_pkg
`default_nettype none

module aspect_fit_window_calc
    import afw_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,

    // apb configuration port
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [APB_AW-1:0]      paddr,
    input  wire logic [APB_DW-1:0]      pwdata,
    output logic      [APB_DW-1:0]      prdata,
    output logic                        pready,

    // request stream
    input  wire logic                   i_s_tvalid,
    output logic                        o_s_tready,
    // in_width[11:0], in_height[23:12], fit_mode[26:24], aspect_byte[34:27], zero pad
    input  wire logic [IN_TDATA_W-1:0]  i_s_tdata,

    // result stream
    output logic                        o_m_tvalid,
    input  wire logic                   i_m_tready,
    // src_width[11:0], src_height[23:12], out_x[34:24], out_y[45:35],
    // out_width[57:46], out_height[69:58], zero pad
    output logic      [OUT_TDATA_W-1:0] o_m_tdata
);

    // ------------------------------------------------------------------
    // panel registers
    // ------------------------------------------------------------------
    logic [DIM_W-1:0] r_pw;
    logic [DIM_W-1:0] r_ph;
    logic             cfg_wr;
    t_reg_idx         cfg_idx;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;
    // registers sit at word addresses, byte lanes below are ignored
    assign cfg_idx = t_reg_idx'(paddr[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pw <= PANEL_W_RST;
            r_ph <= PANEL_H_RST;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_PANEL_W: r_pw <= pwdata[DIM_W-1:0];
                REG_PANEL_H: r_ph <= pwdata[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (cfg_idx)
            REG_PANEL_W: prdata = {{(APB_DW-DIM_W){1'b0}}, r_pw};
            REG_PANEL_H: prdata = {{(APB_DW-DIM_W){1'b0}}, r_ph};
            default: prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // stage flow control: a stage loads when it is empty or its
    // contents move on, so bubbles collapse under a stalled output
    // ------------------------------------------------------------------
    logic [NSTG-1:0] r_v;
    logic [NSTG-1:0] en;

    always_comb begin
        en[NSTG-1] = !r_v[NSTG-1] || i_m_tready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    assign o_s_tready = en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) begin
                r_v[0] <= i_s_tvalid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 0: clamp the source, pick the target ratio w:h
    // ------------------------------------------------------------------
    logic [DIM_W-1:0] in_w;
    logic [DIM_W-1:0] in_h;
    logic [2:0]       in_mode;
    logic [3:0]       in_code;
    logic [DIM_W-1:0] iw_c;
    logic [DIM_W-1:0] ih_c;
    t_prep            n_prep;
    t_prep            r_prep;

    assign in_w    = i_s_tdata[11:0];
    assign in_h    = i_s_tdata[23:12];
    assign in_mode = i_s_tdata[26:24];
    assign in_code = i_s_tdata[34:31];   // upper nibble of aspect_byte

    always_comb begin
        iw_c = (in_w < MIN_W) ? MIN_W : in_w;
        ih_c = (in_h < MIN_H) ? MIN_H : in_h;
        // coded 1088-line hd is shown as 1080 lines
        if (iw_c == HD_W && ih_c == HD_H_CODED) begin
            ih_c = HD_H;
        end

        n_prep.orig = (in_mode == MODE_ORIG);
        // original mode crops the source to the panel
        n_prep.iw = (n_prep.orig && iw_c > r_pw) ? r_pw : iw_c;
        n_prep.ih = (n_prep.orig && ih_c > r_ph) ? r_ph : ih_c;

        n_prep.w = iw_c;
        n_prep.h = ih_c;
        case (in_mode)
            MODE_4_3: begin
                n_prep.w = RATIO_4_3;
                n_prep.h = RATIO_UNIT;
            end
            MODE_16_9: begin
                n_prep.w = RATIO_16_9;
                n_prep.h = RATIO_UNIT;
            end
            MODE_221: begin
                n_prep.w = RATIO_221;
                n_prep.h = RATIO_UNIT;
            end
            default: begin
                // auto: header aspect code, else pal as 4:3, else pixel size
                case (in_code)
                    ASP_4_3: begin
                        n_prep.w = RATIO_4_3;
                        n_prep.h = RATIO_UNIT;
                    end
                    ASP_16_9: begin
                        n_prep.w = RATIO_16_9;
                        n_prep.h = RATIO_UNIT;
                    end
                    ASP_221: begin
                        n_prep.w = RATIO_221;
                        n_prep.h = RATIO_UNIT;
                    end
                    default: begin
                        if (iw_c == PAL_W && ih_c == PAL_H) begin
                            n_prep.w = PAL_4_3_W;
                        end
                    end
                endcase
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_prep <= n_prep;
        end
    end

    // ------------------------------------------------------------------
    // stage 1: cross products w*ph and pw*h
    // ------------------------------------------------------------------
    t_prod n_prod;
    t_prod r_prod;

    always_comb begin
        n_prod.iw   = r_prep.iw;
        n_prod.ih   = r_prep.ih;
        n_prod.orig = r_prep.orig;
        n_prod.w    = r_prep.w;
        n_prod.h    = r_prep.h;
        n_prod.wph  = {{DIM_W{1'b0}}, r_prep.w} * {{DIM_W{1'b0}}, r_ph};
        n_prod.pwh  = {{DIM_W{1'b0}}, r_pw} * {{DIM_W{1'b0}}, r_prep.h};
    end

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_prod <= n_prod;
        end
    end

    // ------------------------------------------------------------------
    // stage 2: compare and set up the division
    // wider target: out_height = pw*h / w, else out_width = ph*w / h;
    // the quotient never exceeds 12 bits, so the top half of the
    // dividend is already below the divisor
    // ------------------------------------------------------------------
    t_div              r_d [DIV_STAGES+1];
    t_div              n_d0;
    logic [PROD_W-1:0] dvd;

    always_comb begin
        n_d0.iw   = r_prod.iw;
        n_d0.ih   = r_prod.ih;
        n_d0.orig = r_prod.orig;
        n_d0.wide = (r_prod.wph > r_prod.pwh);
        dvd       = n_d0.wide ? r_prod.pwh : r_prod.wph;
        n_d0.den  = n_d0.wide ? r_prod.w : r_prod.h;
        n_d0.rem  = dvd[PROD_W-1:DIM_W];
        n_d0.num  = dvd[DIM_W-1:0];
        n_d0.q    = '0;
    end

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r_d[0] <= n_d0;
        end
    end

    // ------------------------------------------------------------------
    // stages 3..8: restoring divider, two quotient bits per stage
    // ------------------------------------------------------------------
    function automatic t_div div_stage(input t_div d_in);
        t_div          d;
        logic [DIM_W:0] t;
        logic [DIM_W:0] diff;
        d = d_in;
        for (int j = 0; j < DIV_BITS; j++) begin
            t     = {d.rem, d.num[DIM_W-1]};
            diff  = t - {1'b0, d.den};
            d.num = {d.num[DIM_W-2:0], 1'b0};
            if (t >= {1'b0, d.den}) begin
                d.rem = diff[DIM_W-1:0];
                d.q   = {d.q[DIM_W-2:0], 1'b1};
            end else begin
                d.rem = t[DIM_W-1:0];
                d.q   = {d.q[DIM_W-2:0], 1'b0};
            end
        end
        return d;
    endfunction

    for (genvar g = 1; g <= DIV_STAGES; g++) begin : g_div
        always_ff @(posedge i_clk) begin
            if (en[g+2]) begin
                r_d[g] <= div_stage(r_d[g-1]);
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 9: pick the window, clamp to the panel, centre
    // ------------------------------------------------------------------
    t_div             d_last;
    t_res             n_res;
    t_res             r_res;
    logic [DIM_W-1:0] ow;
    logic [DIM_W-1:0] oh;
    logic [DIM_W-1:0] gap_w;
    logic [DIM_W-1:0] gap_h;

    assign d_last = r_d[DIV_STAGES];

    always_comb begin
        if (d_last.orig) begin
            ow = d_last.iw;
            oh = d_last.ih;
        end else if (d_last.wide) begin
            ow = r_pw;
            oh = d_last.q;
        end else begin
            ow = d_last.q;
            oh = r_ph;
        end
        if (ow > r_pw) begin
            ow = r_pw;
        end
        if (oh > r_ph) begin
            oh = r_ph;
        end
        gap_w       = r_pw - ow;
        gap_h       = r_ph - oh;
        n_res.src_w = d_last.iw;
        n_res.src_h = d_last.ih;
        n_res.out_x = gap_w[DIM_W-1:1];
        n_res.out_y = gap_h[DIM_W-1:1];
        n_res.out_w = ow;
        n_res.out_h = oh;
    end

    always_ff @(posedge i_clk) begin
        if (en[NSTG-1]) begin
            r_res <= n_res;
        end
    end

    assign o_m_tvalid = r_v[NSTG-1];
    assign o_m_tdata  = {{(OUT_TDATA_W - $bits(t_res)){1'b0}}, r_res};

`ifndef SYNTHESIS
    // a refused beat means every stage holds an item
    a_full_when_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> (&r_v))
        else $error("input stalled with an empty stage");

    // the dividend's top half must be below the divisor
    a_div_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[2] |-> (r_d[0].rem < r_d[0].den))
        else $error("quotient does not fit in the divider");

    a_div_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[NSTG-2] |-> (r_d[DIV_STAGES].rem < r_d[DIV_STAGES].den))
        else $error("divider remainder not reduced");

    a_win_w: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (r_res.out_w <= r_pw))
        else $error("window wider than panel");

    a_win_h: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (r_res.out_h <= r_ph))
        else $error("window taller than panel");
`endif

endmodule

`default_nettype wire
